>>> rtl/core/ssbi_pkg.sv
`timescale 1ns / 1ps
package ssbi_pkg;

  localparam int DATA_W          = 32;
  localparam int BURST_W         = 8;
  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  // register index sits above the byte offset
  localparam int REG_IDX_LSB  = 2;
  localparam logic [APB_ADDR_W-REG_IDX_LSB-1:0] REG_BURST_LENGTH = '0;

  localparam logic [BURST_W-1:0] BURST_LENGTH_RST = 8'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SERVE,
    S_FLUSH
  } state_t;

endpackage

>>> rtl/core/ssbi_ram.sv
`timescale 1ns / 1ps
module ssbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/sign_split_burst_interleaver_core.sv
`timescale 1ns / 1ps
// Sign-split burst interleaver.
// Input channel (value, end_of_stream) and output channel (out_value, has_value,
// run_last, overflow) both use valid/ready; a transfer happens when both are high.
// Non-zero words are queued by sign in two memories of QUEUE_DEPTH words; zeros
// are dropped, and a word pushed into a full queue is lost and sets the sticky
// overflow flag. Each item may pop one word from the side being served; the side
// toggles after burst_length words. An item with end_of_stream flushes the
// positive queue, then the negative one, marking the last result with run_last,
// or gives one marker result (has_value low) when nothing is left.
// Timing: an item is pushed in its acceptance cycle; its popped word is read from
// the queue memory, then loaded into the output register. No new item is taken
// while the item in hand is being served. The flush issues a new queue read only
// once the previous read has been loaded into the output register.
// The output register frees the input side: an item is accepted while a result
// waits, but no further memory read is issued until that result is taken.
// Reset (rst, synchronous) empties both queues, clears overflow, serves the
// positive side first and sets burst_length to 5; no memory clearing pass.
module sign_split_burst_interleaver_core
  import ssbi_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [DATA_W-1:0] value,
  input  logic                    end_of_stream,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                    has_value,
  output logic                    run_last,
  output logic                    overflow,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  state_t state, state_next;

  logic [BURST_W-1:0] burst_length;
  logic [PTR_W-1:0]   pos_head, neg_head;
  logic [CNT_W-1:0]   pos_count, neg_count;
  logic               serve_pos;
  logic [BURST_W-1:0] burst_count;
  logic               overflow_seen;
  logic               eos_hold;
  logic               emitted;

  logic               rd_pend;
  logic               pend_pos;
  logic               pend_last;
  logic               pend_ovf;

  logic               accept;
  logic               out_free;
  logic               reg_hit;
  logic               cfg_write;
  logic               push_neg;
  logic               push_ok;
  logic               push_drop;
  logic [SUM_W-1:0]   push_sum;
  logic [PTR_W-1:0]   push_idx;
  logic               serve_nz;
  logic               issue;
  logic               issue_pos;
  logic               issue_last;
  logic               marker;
  logic               finish;
  logic [SUM_W-1:0]   total;
  logic [PTR_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  pos_rdata, neg_rdata;

  // configuration port
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[APB_ADDR_W-1:REG_IDX_LSB] == REG_BURST_LENGTH);
  assign cfg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? APB_DATA_W'(burst_length) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_length <= BURST_LENGTH_RST;
    end else if (cfg_write) begin
      burst_length <= pwdata[BURST_W-1:0];
    end
  end

  // push side
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign push_neg  = value[DATA_W-1];
  assign push_ok   = accept && (value != '0) &&
                     ((push_neg ? neg_count : pos_count) != FULL_CNT);
  assign push_drop = accept && (value != '0) &&
                     ((push_neg ? neg_count : pos_count) == FULL_CNT);

  // tail slot is head + count, wrapped once
  always_comb begin
    push_sum = push_neg ? (SUM_W'(neg_head) + SUM_W'(neg_count))
                        : (SUM_W'(pos_head) + SUM_W'(pos_count));
    if (push_sum >= SUM_W'(QUEUE_DEPTH)) begin
      push_idx = PTR_W'(push_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      push_idx = PTR_W'(push_sum);
    end
  end

  // a read may issue only when its data can land in a free output register
  assign out_free = (!out_valid || out_ready) && !rd_pend;
  assign serve_nz = serve_pos ? (pos_count != '0) : (neg_count != '0);
  assign total    = SUM_W'(pos_count) + SUM_W'(neg_count);

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    issue_pos  = 1'b1;
    marker     = 1'b0;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SERVE;
        end
      end
      S_SERVE: begin
        if (!serve_nz) begin
          state_next = eos_hold ? S_FLUSH : S_IDLE;
        end else if (out_free) begin
          issue      = 1'b1;
          issue_pos  = serve_pos;
          state_next = eos_hold ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (pos_count != '0) begin
          issue     = out_free;
          issue_pos = 1'b1;
        end else if (neg_count != '0) begin
          issue     = out_free;
          issue_pos = 1'b0;
        end else if (emitted) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else if (out_free) begin
          marker     = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // this pop empties both queues
  assign issue_last = eos_hold && (total == SUM_W'(1));
  assign rd_addr    = issue_pos ? pos_head : neg_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_head      <= '0;
      neg_head      <= '0;
      pos_count     <= '0;
      neg_count     <= '0;
      serve_pos     <= 1'b1;
      burst_count   <= '0;
      overflow_seen <= 1'b0;
      eos_hold      <= 1'b0;
      emitted       <= 1'b0;
      rd_pend       <= 1'b0;
      pend_pos      <= 1'b0;
      pend_last     <= 1'b0;
      pend_ovf      <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (accept) begin
        eos_hold <= end_of_stream;
        emitted  <= 1'b0;
        if (burst_count >= burst_length) begin
          serve_pos   <= !serve_pos;
          burst_count <= '0;
        end
      end
      if (push_ok) begin
        if (push_neg) begin
          neg_count <= neg_count + CNT_W'(1);
        end else begin
          pos_count <= pos_count + CNT_W'(1);
        end
      end
      if (push_drop) begin
        overflow_seen <= 1'b1;
      end
      if (issue) begin
        emitted   <= 1'b1;
        pend_pos  <= issue_pos;
        pend_last <= issue_last;
        pend_ovf  <= overflow_seen;
        if (issue_pos) begin
          pos_head  <= (pos_head == LAST_PTR) ? '0 : pos_head + PTR_W'(1);
          pos_count <= pos_count - CNT_W'(1);
        end else begin
          neg_head  <= (neg_head == LAST_PTR) ? '0 : neg_head + PTR_W'(1);
          neg_count <= neg_count - CNT_W'(1);
        end
        if (state == S_SERVE) begin
          burst_count <= burst_count + BURST_W'(1);
        end
      end
      if (finish) begin
        serve_pos   <= 1'b1;
        burst_count <= '0;
      end
    end
  end

  ssbi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_pos_ram (
    .clk   (clk),
    .we    (push_ok && !push_neg),
    .waddr (push_idx),
    .wdata (value),
    .re    (issue && issue_pos),
    .raddr (rd_addr),
    .rdata (pos_rdata)
  );

  ssbi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_neg_ram (
    .clk   (clk),
    .we    (push_ok && push_neg),
    .waddr (push_idx),
    .wdata (value),
    .re    (issue && !issue_pos),
    .raddr (rd_addr),
    .rdata (neg_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pend || marker) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      out_value <= pend_pos ? pos_rdata : neg_rdata;
      has_value <= 1'b1;
      run_last  <= pend_last;
      overflow  <= pend_ovf;
    end else if (marker) begin
      out_value <= '0;
      has_value <= 1'b0;
      run_last  <= 1'b1;
      overflow  <= overflow_seen;
    end
  end

`ifndef ASSERT_OFF
  // pushes and pops are kept to separate cycles, so no forwarding is needed
  a_no_push_with_pop: assert property (@(posedge clk) disable iff (rst)
    !(accept && issue))
    else $error("queue push and pop in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (pos_count <= FULL_CNT) && (neg_count <= FULL_CNT))
    else $error("queue count beyond depth");

  // memory read, then output register load
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    issue |=> ##1 (out_valid && has_value && (run_last == $past(issue_last, 2))))
    else $error("memory read did not reach output register");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    marker |=> out_valid && !has_value && run_last && (out_value == '0))
    else $error("malformed end of stream marker");

  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    finish |=> serve_pos && (burst_count == '0) && (pos_count == '0) &&
               (neg_count == '0))
    else $error("stream did not restart cleanly after flush");
`endif

endmodule

>>> tb/sign_split_burst_interleaver_core_test.sv
`timescale 1ns / 1ps
module sign_split_burst_interleaver_core_test;
  import ssbi_pkg::*;

  localparam int FIFO_DEPTH    = QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [APB_ADDR_W-1:0] BURST_LENGTH_ADDR =
    {REG_BURST_LENGTH, {REG_IDX_LSB{1'b0}}};

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct {
    word_t word;
    logic  has_word;
    logic  closes_run;
    logic  sticky_ovf;
  } emit_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  word_t                 value = '0;
  logic                  end_of_stream = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  word_t                 out_value;
  logic                  has_value;
  logic                  run_last;
  logic                  overflow;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // predicted state of the block
  word_t              pos_words[$];
  word_t              neg_words[$];
  logic [BURST_W-1:0] burst_len = BURST_LENGTH_RST;
  logic [BURST_W-1:0] burst_done = '0;
  logic               on_positive = 1'b1;
  logic               ovf_seen = 1'b0;
  emit_t              expected_emits[$];

  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  int settings_written = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  sign_split_burst_interleaver_core #(
    .QUEUE_DEPTH(FIFO_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .end_of_stream(end_of_stream),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_value(out_value),
    .has_value(has_value),
    .run_last(run_last),
    .overflow(overflow),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic emit_t make_emit(input word_t w, input logic has, input logic last);
    emit_t e;
    e.word = w;
    e.has_word = has;
    e.closes_run = last;
    e.sticky_ovf = ovf_seen;
    return e;
  endfunction

  // sorts one word by sign, serves the current side, flushes on end of stream
  function automatic void interleave_word(input word_t w, input logic eos);
    emit_t step_out[$];
    emit_t e;
    if (w != 0) begin
      if (w[DATA_W-1]) begin
        if (neg_words.size() < FIFO_DEPTH) neg_words.push_back(w);
        else ovf_seen = 1'b1;
      end else begin
        if (pos_words.size() < FIFO_DEPTH) pos_words.push_back(w);
        else ovf_seen = 1'b1;
      end
    end
    if (burst_done >= burst_len) begin
      on_positive = !on_positive;
      burst_done = '0;
    end
    if (on_positive && pos_words.size() > 0) begin
      step_out.push_back(make_emit(pos_words.pop_front(), 1'b1, 1'b0));
      burst_done = burst_done + BURST_W'(1);
    end else if (!on_positive && neg_words.size() > 0) begin
      step_out.push_back(make_emit(neg_words.pop_front(), 1'b1, 1'b0));
      burst_done = burst_done + BURST_W'(1);
    end
    if (eos) begin
      while (pos_words.size() > 0) step_out.push_back(make_emit(pos_words.pop_front(), 1'b1, 1'b0));
      while (neg_words.size() > 0) step_out.push_back(make_emit(neg_words.pop_front(), 1'b1, 1'b0));
      if (step_out.size() == 0) begin
        step_out.push_back(make_emit('0, 1'b0, 1'b1));
      end else begin
        e = step_out.pop_back();
        e.closes_run = 1'b1;
        step_out.push_back(e);
      end
      on_positive = 1'b1;
      burst_done = '0;
    end
    foreach (step_out[i]) expected_emits.push_back(step_out[i]);
  endfunction

  function automatic void check_field(input string what, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // input transfers are predicted before output transfers of the same edge are checked
  always @(posedge clk) begin : monitor
    emit_t e;
    if (!rst) begin
      if (in_valid && in_ready) interleave_word(value, end_of_stream);
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_emits.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual value %h has %b last %b ovf %b",
                   $time, out_value, has_value, run_last, overflow);
          errors++;
        end else begin
          e = expected_emits.pop_front();
          check_field("out_value", e.word, out_value);
          check_field("has_value", DATA_W'(e.has_word), DATA_W'(has_value));
          check_field("run_last", DATA_W'(e.closes_run), DATA_W'(run_last));
          check_field("overflow", DATA_W'(e.sticky_ovf), DATA_W'(overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (recv_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still expected",
                 $time, STALL_LIMIT, expected_emits.size());
        $display("[sign_split_burst_interleaver_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(input word_t w, input logic eos);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= w;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_emits.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // only while idle; a word with no result may still be in flight after the drain
  task automatic set_burst_length(input logic [BURST_W-1:0] len);
    logic [APB_DATA_W-1:0] rd;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(BURST_LENGTH_ADDR, APB_DATA_W'(len));
    burst_len = len;
    settings_written++;
    apb_read(BURST_LENGTH_ADDR, rd);
    check_field("burst_length readback", APB_DATA_W'(len), rd);
  endtask

  function automatic word_t random_word();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0: return '0;
      1: return word_t'(32'h7FFF_FFFF);
      2: return word_t'(32'h8000_0000);
      3: return $urandom_range(1) ? word_t'(1) : word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_register_reset();
    logic [APB_DATA_W-1:0] rd;
    apb_read(BURST_LENGTH_ADDR, rd);
    check_field("burst_length after reset", APB_DATA_W'(BURST_LENGTH_RST), rd);
  endtask

  task automatic test_field_extremes();
    send_word(word_t'(32'h7FFF_FFFF), 1'b0);
    send_word(word_t'(32'h8000_0000), 1'b0);
    send_word(word_t'(1), 1'b0);
    send_word(word_t'(-1), 1'b0);
    // zero is dropped and gives nothing
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    wait_idle();
  endtask

  task automatic test_empty_end();
    // nothing queued: marker result only
    send_word('0, 1'b1);
    send_word(word_t'(-5), 1'b1);
    wait_idle();
  endtask

  task automatic test_burst_extremes();
    set_burst_length(8'd1);
    send_word(word_t'(11), 1'b0);
    send_word(word_t'(-12), 1'b0);
    send_word(word_t'(13), 1'b0);
    send_word(word_t'(-14), 1'b0);
    send_word(word_t'(15), 1'b1);
    set_burst_length(8'd255);
    send_word(word_t'(-21), 1'b0);
    send_word(word_t'(22), 1'b0);
    send_word(word_t'(-23), 1'b0);
    send_word(word_t'(24), 1'b0);
    send_word(word_t'(-25), 1'b1);
  endtask

  task automatic test_lowered_burst();
    set_burst_length(8'd5);
    for (int i = 0; i < 4; i++) send_word(word_t'(100 + i), 1'b0);
    send_word(word_t'(-7), 1'b0);
    // burst count already past the new length, so the next word switches side
    set_burst_length(8'd2);
    send_word(word_t'(9), 1'b0);
    send_word('0, 1'b1);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int recv_pct, input int n_items);
    int sent;
    int len;
    int pick;
    sender_idle_pct = sender_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(9);
      case (pick)
        0: set_burst_length(8'd1);
        1: set_burst_length(8'd255);
        2, 3: set_burst_length(BURST_W'($urandom_range(1, 8)));
        4: set_burst_length(BURST_W'($urandom_range(1, 255)));
        5: wait_idle();
        default: ;
      endcase
      len = $urandom_range(1, 16);
      // a quarter of the runs stay open and carry their words into the next one
      for (int i = 0; i < len; i++)
        send_word(random_word(), (i == len - 1) && ($urandom_range(3) != 0));
      sent += len;
    end
    wait_idle();
  endtask

  task automatic test_queue_overflow();
    sender_idle_pct = 12;
    recv_stall_pct = 12;
    set_burst_length(8'd1);
    // one popped positive moves service to the empty negative side
    send_word(word_t'(1), 1'b0);
    for (int i = 0; i < FIFO_DEPTH + 2; i++)
      send_word(word_t'({1'b0, 31'($urandom)} | 1), 1'b0);
    send_word('0, 1'b1);
    // now the positive side is served and stays empty while negatives pile up
    for (int i = 0; i < FIFO_DEPTH + 2; i++)
      send_word(word_t'({1'b1, 31'($urandom)}), 1'b0);
    send_word('0, 1'b1);
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_reset();
    test_field_extremes();
    test_empty_end();
    test_burst_extremes();
    test_lowered_burst();
    test_random_traffic(0, 0, 60);
    test_random_traffic(85, 0, 60);
    test_random_traffic(0, 85, 60);
    test_random_traffic(12, 12, 60);
    test_queue_overflow();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("sent %0d words, checked %0d results over %0d burst length settings",
             words_sent, results_checked, settings_written);
    $display("covered sign extremes, empty flushes, lowered bursts, stalls and queue overflow");
    if (errors == 0) begin
      $display("[sign_split_burst_interleaver_core] OK");
    end else begin
      $display("[sign_split_burst_interleaver_core] ERROR");
    end
    $finish;
  end

endmodule
